FILE: design/rlr_pkg.sv
// Shared widths, register indexes and controller/datapath signal groups.
package rlr_pkg;

  localparam int RADIUS_BITS = 6;
  localparam int RADIUS_MAX  = (1 << RADIUS_BITS) - 1;
  localparam int OFFSET_BITS = RADIUS_BITS + 1;
  localparam int PEAK_BITS   = 8;
  localparam int R2_BITS     = 2 * RADIUS_BITS;
  localparam int D2_BITS     = R2_BITS + 1;
  localparam int SQ_BITS     = 2 * OFFSET_BITS;
  localparam int QUO_BITS    = PEAK_BITS;
  localparam int NUM_BITS    = PEAK_BITS + R2_BITS;
  localparam int STEP_BITS   = $clog2(QUO_BITS);
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [PEAK_BITS-1:0] PEAK_RESET = 8'd255;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK     = 2'd3;

  typedef struct packed {
    logic accept;
    logic sq_en;
    logic mul_en;
    logic div_start;
    logic load_out;
  } rlr_cmd_t;

  typedef struct packed {
    logic div_done;
  } rlr_stat_t;

endpackage

FILE: design/rlr_div.sv
// Restoring divider producing the falloff quotient one bit per cycle.
module rlr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rlr_pkg::NUM_BITS-1:0] num,
  input  logic [rlr_pkg::R2_BITS-1:0]  den,
  output logic [rlr_pkg::QUO_BITS-1:0] quo,
  output logic                         done
);
  import rlr_pkg::*;

  logic                 busy;
  logic [STEP_BITS-1:0] cnt;
  logic [R2_BITS-1:0]   rem;
  logic [QUO_BITS-1:0]  bits;
  logic [R2_BITS:0]     trial;
  logic                 qbit;
  logic [R2_BITS:0]     diff;

  assign trial = {rem, bits[QUO_BITS-1]};
  assign qbit  = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};
  assign quo   = bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_BITS'(QUO_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_BITS'(QUO_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[NUM_BITS-1:QUO_BITS];
      bits <= num[QUO_BITS-1:0];
    end else if (busy) begin
      rem  <= qbit ? diff[R2_BITS-1:0] : trial[R2_BITS-1:0];
      bits <= {bits[QUO_BITS-2:0], qbit};
    end
  end

endmodule

FILE: design/rlr_dp.sv
// Datapath: configuration, scan offsets, distance, falloff product and result item.
module rlr_dp #(
  parameter int MAX_RADIUS = 63,
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [rlr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  logic                                 restart,
  input  rlr_pkg::rlr_cmd_t                    cmd,
  output rlr_pkg::rlr_stat_t                   stat,
  output logic signed [COORD_BITS:0]           pixel_x,
  output logic signed [COORD_BITS:0]           pixel_y,
  output logic [rlr_pkg::PEAK_BITS-1:0]        alpha,
  output logic                                 inside_res,
  output logic                                 last
);
  import rlr_pkg::*;

  localparam int MaxEff = (MAX_RADIUS > RADIUS_MAX) ? RADIUS_MAX : MAX_RADIUS;
  localparam logic [RADIUS_BITS-1:0] MAX_R = RADIUS_BITS'(MaxEff);
  localparam logic signed [OFFSET_BITS-1:0] ONE_S = OFFSET_BITS'(1);

  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0]        radius;
  logic [PEAK_BITS-1:0]          peak;
  logic signed [OFFSET_BITS-1:0] offset_x;
  logic signed [OFFSET_BITS-1:0] offset_y;

  logic signed [OFFSET_BITS-1:0] dx;
  logic signed [OFFSET_BITS-1:0] dy;
  logic signed [COORD_BITS:0]    px;
  logic signed [COORD_BITS:0]    py;
  logic                          last_w;
  logic [D2_BITS-1:0]            d2;
  logic [R2_BITS-1:0]            r2;
  logic                          inside_w;
  logic [NUM_BITS-1:0]           num;

  logic [RADIUS_BITS-1:0]        reff;
  logic [RADIUS_BITS-1:0]        cfg_reff;
  logic signed [OFFSET_BITS-1:0] r_s;
  logic signed [OFFSET_BITS-1:0] neg_r;
  logic signed [OFFSET_BITS-1:0] neg_cfg_r;
  logic signed [OFFSET_BITS-1:0] dx_cur;
  logic signed [OFFSET_BITS-1:0] dy_cur;
  logic signed [SQ_BITS-1:0]     sqx;
  logic signed [SQ_BITS-1:0]     sqy;
  logic [D2_BITS-1:0]            d2_next;
  logic [R2_BITS-1:0]            r2_next;
  logic [R2_BITS-1:0]            diff;
  logic [NUM_BITS-1:0]           num_next;
  logic [QUO_BITS-1:0]           quo;
  logic                          div_done;

  assign reff      = (radius > MAX_R) ? MAX_R : radius;
  assign cfg_reff  = (cfg_data[RADIUS_BITS-1:0] > MAX_R) ? MAX_R : cfg_data[RADIUS_BITS-1:0];
  assign r_s       = $signed({1'b0, reff});
  assign neg_r     = -r_s;
  assign neg_cfg_r = -$signed({1'b0, cfg_reff});
  assign dx_cur    = restart ? neg_r : offset_x;
  assign dy_cur    = restart ? neg_r : offset_y;

  assign sqx      = SQ_BITS'(dx) * SQ_BITS'(dx);
  assign sqy      = SQ_BITS'(dy) * SQ_BITS'(dy);
  assign d2_next  = sqx[D2_BITS-1:0] + sqy[D2_BITS-1:0];
  assign r2_next  = R2_BITS'(reff) * R2_BITS'(reff);
  assign diff     = inside_w ? (r2 - d2[R2_BITS-1:0]) : '0;
  assign num_next = NUM_BITS'(peak) * NUM_BITS'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
      peak     <= PEAK_RESET;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_RADIUS: begin
          radius   <= cfg_data[RADIUS_BITS-1:0];
          offset_x <= neg_cfg_r;
          offset_y <= neg_cfg_r;
        end
        CFG_PEAK:     peak <= cfg_data[PEAK_BITS-1:0];
      endcase
    end else if (cmd.accept) begin
      if (dx_cur < r_s) begin
        offset_x <= dx_cur + ONE_S;
        offset_y <= dy_cur;
      end else begin
        offset_x <= neg_r;
        offset_y <= (dy_cur < r_s) ? dy_cur + ONE_S : neg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dx     <= dx_cur;
      dy     <= dy_cur;
      px     <= (COORD_BITS+1)'(center_x) + (COORD_BITS+1)'(dx_cur);
      py     <= (COORD_BITS+1)'(center_y) + (COORD_BITS+1)'(dy_cur);
      last_w <= (dx_cur == r_s) && (dy_cur == r_s);
    end
    if (cmd.sq_en) begin
      d2       <= d2_next;
      r2       <= r2_next;
      inside_w <= (d2_next <= {1'b0, r2_next});
    end
    if (cmd.mul_en) begin
      num <= num_next;
    end
    if (cmd.load_out) begin
      pixel_x    <= px;
      pixel_y    <= py;
      inside_res <= inside_w;
      last       <= last_w;
      if (!inside_w) begin
        alpha <= '0;
      end else if (r2 == '0) begin
        alpha <= peak;
      end else begin
        alpha <= quo;
      end
    end
  end

  rlr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (r2),
    .quo   (quo),
    .done  (div_done)
  );

  assign stat.div_done = div_done;

endmodule

FILE: design/rlr_ctrl.sv
// Controller: sequences one item through distance, product, divide and result.
module rlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rlr_pkg::rlr_stat_t  stat,
  output rlr_pkg::rlr_cmd_t   cmd
);
  import rlr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/radial_light_raster.sv
// Top level of the radial light raster scanner.
//
// Each accepted item emits one position of the (2r+1) x (2r+1) square around the
// configured center, row by row from the top-left corner; restart=1 emits the
// top-left corner and begins the scan again, and a radius write re-arms it. After
// acceptance an item passes through the squared distance, the intensity product,
// the divider load, the eight-step restoring divider and its done flag, and then
// the load of its result into the output register. One item is in flight at a
// time, so a new item is not accepted until the previous result is loaded; the
// next one is accepted while the previous result still waits on out_stall.
// The user must write configuration only while no item is in flight; the block
// itself does not enforce this.
module radial_light_raster #(
  parameter int MAX_RADIUS = 63,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_BITS:0]         pixel_x,
  output logic signed [COORD_BITS:0]         pixel_y,
  output logic [rlr_pkg::PEAK_BITS-1:0]      alpha,
  output logic                               inside_res,
  output logic                               last
);
  import rlr_pkg::*;

  rlr_cmd_t  cmd;
  rlr_stat_t stat;

  rlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlr_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .restart    (restart),
    .cmd        (cmd),
    .stat       (stat),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .alpha      (alpha),
    .inside_res (inside_res),
    .last       (last)
  );

endmodule

FILE: sim/tb_radial_light_raster.sv
// Self-checking testbench for radial_light_raster: directed table plus random scans.
`timescale 1ns / 1ps

module tb_radial_light_raster;
  import rlr_pkg::*;

  localparam int ITEMS      = 1400;
  localparam int CALM_ITEMS = 200;
  localparam int SETTLE     = 16;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic [7:0]         alpha;
    logic               drawn;
    logic               last;
  } spot_t;

  typedef struct {
    bit                        cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [11:0]               data;
    bit                        rs;
    bit                        typed;
    spot_t                     want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [11:0]               cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      restart;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [12:0]        pixel_x;
  logic signed [12:0]        pixel_y;
  logic [PEAK_BITS-1:0]      alpha;
  logic                      inside_res;
  logic                      last;

  // light model state
  logic signed [11:0] ctr_x;
  logic signed [11:0] ctr_y;
  logic [5:0]         rad;
  logic [7:0]         peak;
  int                 off_x;
  int                 off_y;

  spot_t pending_spots[$];
  int    errors = 0;
  int    sent = 0;
  int    cycles = 0;
  int    stall_left = 0;
  bit    calm = 1'b0;
  bit    quiet = 1'b0;

  radial_light_raster dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .alpha      (alpha),
    .inside_res (inside_res),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic spot_t spot(int px, int py, int a, bit in_b, bit l);
    spot_t s;
    s.px     = 13'(px);
    s.py     = 13'(py);
    s.alpha  = 8'(a);
    s.drawn  = in_b;
    s.last   = l;
    return s;
  endfunction

  function automatic row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx, logic [11:0] data);
    row_t w;
    w       = '{default: '0};
    w.cfg   = 1'b1;
    w.idx   = idx;
    w.data  = data;
    return w;
  endfunction

  function automatic row_t item_row(bit rs);
    row_t w;
    w    = '{default: '0};
    w.rs = rs;
    return w;
  endfunction

  function automatic row_t typed_row(bit rs, spot_t want);
    row_t w;
    w       = item_row(rs);
    w.typed = 1'b1;
    w.want  = want;
    return w;
  endfunction

  // compute the next scan position and advance the offsets
  function automatic spot_t shade_next(bit rs);
    int    r;
    int    dx;
    int    dy;
    int    d2;
    int    r2;
    spot_t s;
    r = int'(rad);
    if (rs) begin
      off_x = -r;
      off_y = -r;
    end
    dx = off_x;
    dy = off_y;
    d2 = dx * dx + dy * dy;
    r2 = r * r;
    s.drawn = (d2 <= r2);
    if (d2 > r2) begin
      s.alpha = '0;
    end else if (r2 == 0) begin
      s.alpha = peak;
    end else begin
      s.alpha = 8'((int'(peak) * (r2 - d2)) / r2);
    end
    s.px   = 13'(int'(ctr_x) + dx);
    s.py   = 13'(int'(ctr_y) + dy);
    s.last = (dx == r) && (dy == r);
    if (dx < r) begin
      off_x = dx + 1;
    end else begin
      off_x = -r;
      off_y = (dy < r) ? dy + 1 : -r;
    end
    return s;
  endfunction

  task automatic report_miss(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(bit rs, bit typed, spot_t want);
    spot_t s;
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      idle_sender($urandom_range(1, 11));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    s = shade_next(rs);
    pending_spots.push_back(typed ? want : s);
    sent++;
  endtask

  // hold off until every pending item has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [11:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_CENTER_X: ctr_x = data;
      CFG_CENTER_Y: ctr_y = data;
      CFG_RADIUS: begin
        rad   = data[5:0];
        off_x = -int'(rad);
        off_y = -int'(rad);
      end
      CFG_PEAK: peak = data[7:0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    spot_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_spots.size() == 0) begin
        report_miss($sformatf("item (%0d,%0d) with nothing pending", pixel_x, pixel_y));
      end else begin
        want = pending_spots.pop_front();
        if (pixel_x !== want.px)
          report_miss($sformatf("pixel_x got %0d want %0d", pixel_x, want.px));
        if (pixel_y !== want.py)
          report_miss($sformatf("pixel_y got %0d want %0d", pixel_y, want.py));
        if (alpha !== want.alpha)
          report_miss($sformatf("alpha got %0d want %0d at (%0d,%0d)",
                                alpha, want.alpha, want.px, want.py));
        if (inside_res !== want.drawn)
          report_miss($sformatf("inside_res got %0b want %0b at (%0d,%0d)",
                                inside_res, want.drawn, want.px, want.py));
        if (last !== want.last)
          report_miss($sformatf("last got %0b want %0b at (%0d,%0d)",
                                last, want.last, want.px, want.py));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t        plan[$];
    int          n;
    int          k;
    int          r;
    logic [11:0] d;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    restart   = 1'b0;
    ctr_x     = '0;
    ctr_y     = '0;
    rad       = '0;
    peak      = PEAK_RESET;
    off_x     = 0;
    off_y     = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    plan.push_back(typed_row(1'b0, spot(0, 0, 255, 1, 1)));
    plan.push_back(typed_row(1'b1, spot(0, 0, 255, 1, 1)));
    plan.push_back(cfg_row(CFG_PEAK, 12'hF00));
    plan.push_back(typed_row(1'b0, spot(0, 0, 0, 1, 1)));
    plan.push_back(cfg_row(CFG_CENTER_X, 12'h7FF));
    plan.push_back(cfg_row(CFG_CENTER_Y, 12'h800));
    plan.push_back(cfg_row(CFG_PEAK, 12'hAFF));
    plan.push_back(typed_row(1'b0, spot(2047, -2048, 255, 1, 1)));
    plan.push_back(cfg_row(CFG_RADIUS, 12'hFFF));
    plan.push_back(typed_row(1'b0, spot(1984, -2111, 0, 0, 0)));
    plan.push_back(item_row(1'b0));
    plan.push_back(cfg_row(CFG_RADIUS, 12'h041));
    plan.push_back(typed_row(1'b0, spot(2046, -2049, 0, 0, 0)));
    repeat (9) plan.push_back(item_row(1'b0));
    plan.push_back(cfg_row(CFG_CENTER_X, 12'h800));
    plan.push_back(cfg_row(CFG_CENTER_Y, 12'h7FF));
    plan.push_back(cfg_row(CFG_RADIUS, 12'h03F));
    plan.push_back(typed_row(1'b1, spot(-2111, 1984, 0, 0, 0)));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b0));
    plan.push_back(cfg_row(CFG_RADIUS, 12'h002));
    plan.push_back(cfg_row(CFG_PEAK, 12'h5C8));
    plan.push_back(item_row(1'b0));
    plan.push_back(item_row(1'b1));
    repeat (3) plan.push_back(item_row(1'b0));

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].rs, plan[i].typed, plan[i].want);
      end
    end

    while (sent < ITEMS) begin
      drain();
      if ($urandom_range(0, 1)) begin
        d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'h800 : 12'h7FF)
                                         : 12'($urandom);
        write_reg(CFG_CENTER_X, d);
      end
      if ($urandom_range(0, 1)) begin
        d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'h800 : 12'h7FF)
                                         : 12'($urandom);
        write_reg(CFG_CENTER_Y, d);
      end
      if ($urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, 9);
        r = (k < 7) ? $urandom_range(0, 5) : ((k < 9) ? $urandom_range(6, 20) : 63);
        write_reg(CFG_RADIUS, {6'($urandom), 6'(r)});
      end
      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, 7);
        r = (k == 0) ? 0 : ((k == 1) ? 255 : $urandom_range(0, 255));
        write_reg(CFG_PEAK, {4'($urandom), 8'(r)});
      end
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 150);
      repeat (n) begin
        calm = (sent >= ITEMS - CALM_ITEMS);
        send_item($urandom_range(0, 19) == 0, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spots.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
